// ===== rtl/core/alu32f_pkg.sv =====
// ----------------------------------------------------------------------------
// alu32f_pkg
// Operation codes and sequencer state type shared by the integer ALU.
// ----------------------------------------------------------------------------
package alu32f_pkg;

    // Operation codes carried in the request's tuser field.
    localparam logic [3:0] FN_ADD  = 4'd0;
    localparam logic [3:0] FN_SUB  = 4'd1;
    localparam logic [3:0] FN_MUL  = 4'd2;
    localparam logic [3:0] FN_DIV  = 4'd3;
    localparam logic [3:0] FN_MOD  = 4'd4;
    localparam logic [3:0] FN_AND  = 4'd5;
    localparam logic [3:0] FN_OR   = 4'd6;
    localparam logic [3:0] FN_XOR  = 4'd7;
    localparam logic [3:0] FN_NOT  = 4'd8;
    localparam logic [3:0] FN_SHL  = 4'd9;
    localparam logic [3:0] FN_SHR  = 4'd10;
    localparam logic [3:0] FN_SHRA = 4'd11;

    localparam int unsigned FUNC_W = 4;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_FIX,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/core/alu_32bit_with_flags.sv =====
// ----------------------------------------------------------------------------
// alu_32bit_with_flags
// Signed integer ALU with overflow and divide-by-zero flags.
// ----------------------------------------------------------------------------
// Add, sub, logic, shifts, a zero divisor and unused codes go from ST_IDLE
// straight to ST_DONE; mul, div and mod run ST_ITER, the radix-2 shift-add /
// restoring-divide loop on the one shared adder, then ST_FIX to apply the
// sign. A request is taken only in ST_IDLE, and ST_DONE waits for the output
// register, so only one request is in flight at a time.
// Reset (synchronous, active low) empties the block and clears the last result.
// ----------------------------------------------------------------------------
module alu_32bit_with_flags #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Request side.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, lowest bit up: operand_a, operand_b, zero padding to bytes.
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // tuser: func.
    input  logic [alu32f_pkg::FUNC_W-1:0]          s_axis_tuser,
    // Result side.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata, lowest bit up: result, zero padding to bytes.
    output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
    // tuser, lowest bit up: overflow, divide_by_zero.
    output logic [1:0]                             m_axis_tuser
);

    localparam int DW  = DATA_WIDTH;
    localparam int CW  = $clog2(DATA_WIDTH);
    localparam int AW  = DATA_WIDTH + 2;

    // Sequencer and working registers.
    alu32f_pkg::t_state r_state, n_state;
    logic [3:0]    r_func,  n_func;
    logic          r_neg,   n_neg;
    logic [CW-1:0] r_cnt,   n_cnt;
    // r_hi/r_lo form the product (high/low halves) during a multiply and the
    // remainder/quotient pair during a divide. r_y is the addend or divisor.
    logic [DW-1:0] r_hi,    n_hi;
    logic [DW-1:0] r_lo,    n_lo;
    logic [DW-1:0] r_y,     n_y;
    logic [DW-1:0] r_res,   n_res;
    logic          r_ovf,   n_ovf;
    logic          r_dbz,   n_dbz;
    logic          r_wr,    n_wr;

    // Output register and the architectural last result.
    logic          r_m_valid, n_m_valid;
    logic [DW-1:0] r_m_res,   n_m_res;
    logic          r_m_ovf,   n_m_ovf;
    logic          r_m_dbz,   n_m_dbz;
    logic [DW-1:0] r_last,    n_last;

    // Request fields.
    logic [DW-1:0] in_a, in_b;
    logic          sa, sb;
    logic [DW-1:0] mag_a, mag_b;
    logic [DW-1:0] sum_ab, dif_ab;
    logic          big_shift;
    logic [CW-1:0] sh_amt;
    logic          req_fire;

    // Shared adder: au_x + au_y, or au_x - au_y when au_sub is set.
    logic [AW-1:0] au_x, au_y, au_sum;
    logic          au_sub;

    logic          div_ge;
    logic [DW-1:0] fix_val;

    assign in_a   = s_axis_tdata[DW-1:0];
    assign in_b   = s_axis_tdata[2*DW-1:DW];
    assign sa     = in_a[DW-1];
    assign sb     = in_b[DW-1];
    assign mag_a  = sa ? (~in_a + DW'(1)) : in_a;
    assign mag_b  = sb ? (~in_b + DW'(1)) : in_b;
    assign sum_ab = in_a + in_b;
    assign dif_ab = in_a - in_b;

    // A count of DATA_WIDTH or more shifts everything out; below that the
    // count fits in CW bits.
    assign big_shift = (in_b >= DW'(DATA_WIDTH));
    assign sh_amt    = in_b[CW-1:0];

    assign s_axis_tready = (r_state == alu32f_pkg::ST_IDLE);
    assign req_fire      = s_axis_tvalid && s_axis_tready;

    assign au_sum = au_x + (au_sub ? ~au_y : au_y) + AW'(au_sub);
    // The trial subtraction of a divide step succeeds when no borrow shows.
    assign div_ge = ~au_sum[AW-1];

    // The quotient sits in r_lo after a divide, the product's low half after
    // a multiply; the remainder sits in r_hi.
    assign fix_val = (r_func == alu32f_pkg::FN_MOD) ? r_hi : r_lo;

    // Shared adder operand selection.
    always_comb begin
        au_x   = '0;
        au_y   = '0;
        au_sub = 1'b0;
        case (r_state)
            alu32f_pkg::ST_ITER: begin
                if (r_func == alu32f_pkg::FN_MUL) begin
                    au_x   = {2'b00, r_hi};
                    au_y   = r_lo[0] ? {2'b00, r_y} : '0;
                    au_sub = 1'b0;
                end else begin
                    au_x   = {1'b0, r_hi, r_lo[DW-1]};
                    au_y   = {2'b00, r_y};
                    au_sub = 1'b1;
                end
            end
            alu32f_pkg::ST_FIX: begin
                au_x   = '0;
                au_y   = {2'b00, fix_val};
                au_sub = r_neg;
            end
            default: begin
                au_x   = '0;
                au_y   = '0;
                au_sub = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            alu32f_pkg::ST_IDLE: begin
                if (req_fire) begin
                    case (s_axis_tuser)
                        alu32f_pkg::FN_MUL: n_state = alu32f_pkg::ST_ITER;
                        alu32f_pkg::FN_DIV,
                        alu32f_pkg::FN_MOD: begin
                            n_state = (in_b == '0) ? alu32f_pkg::ST_DONE
                                                   : alu32f_pkg::ST_ITER;
                        end
                        default: n_state = alu32f_pkg::ST_DONE;
                    endcase
                end
            end
            alu32f_pkg::ST_ITER: begin
                if (r_cnt == '0) begin
                    n_state = alu32f_pkg::ST_FIX;
                end
            end
            alu32f_pkg::ST_FIX: begin
                n_state = alu32f_pkg::ST_DONE;
            end
            alu32f_pkg::ST_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = alu32f_pkg::ST_IDLE;
                end
            end
            default: n_state = alu32f_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register next values.
    always_comb begin
        n_func    = r_func;
        n_neg     = r_neg;
        n_cnt     = r_cnt;
        n_hi      = r_hi;
        n_lo      = r_lo;
        n_y       = r_y;
        n_res     = r_res;
        n_ovf     = r_ovf;
        n_dbz     = r_dbz;
        n_wr      = r_wr;
        n_m_valid = r_m_valid;
        n_m_res   = r_m_res;
        n_m_ovf   = r_m_ovf;
        n_m_dbz   = r_m_dbz;
        n_last    = r_last;

        if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            alu32f_pkg::ST_IDLE: begin
                if (req_fire) begin
                    n_func = s_axis_tuser;
                    n_ovf  = 1'b0;
                    n_dbz  = 1'b0;
                    n_wr   = 1'b1;
                    n_res  = r_last;
                    n_cnt  = CW'(DATA_WIDTH - 1);
                    n_hi   = '0;
                    case (s_axis_tuser)
                        alu32f_pkg::FN_ADD: begin
                            n_res = sum_ab;
                            n_ovf = (sa == sb) && (sum_ab[DW-1] != sa);
                        end
                        alu32f_pkg::FN_SUB: begin
                            n_res = dif_ab;
                            n_ovf = (sa != sb) && (dif_ab[DW-1] != sa);
                        end
                        alu32f_pkg::FN_MUL: begin
                            n_lo  = mag_b;
                            n_y   = mag_a;
                            n_neg = sa ^ sb;
                        end
                        alu32f_pkg::FN_DIV,
                        alu32f_pkg::FN_MOD: begin
                            if (in_b == '0) begin
                                // Zero divisor: repeat the last result.
                                n_dbz = 1'b1;
                                n_wr  = 1'b0;
                            end else begin
                                n_lo  = mag_a;
                                n_y   = mag_b;
                                n_neg = (s_axis_tuser == alu32f_pkg::FN_DIV) ? (sa ^ sb)
                                                                             : sa;
                            end
                        end
                        alu32f_pkg::FN_AND: n_res = in_a & in_b;
                        alu32f_pkg::FN_OR:  n_res = in_a | in_b;
                        alu32f_pkg::FN_XOR: n_res = in_a ^ in_b;
                        alu32f_pkg::FN_NOT: n_res = ~in_a;
                        alu32f_pkg::FN_SHL: n_res = big_shift ? '0 : (in_a << sh_amt);
                        alu32f_pkg::FN_SHR: n_res = big_shift ? '0 : (in_a >> sh_amt);
                        alu32f_pkg::FN_SHRA: begin
                            n_res = big_shift ? {DW{sa}}
                                              : DW'($signed(in_a) >>> sh_amt);
                        end
                        default: begin
                            // Unused code: repeat the last result, no flags.
                            n_wr = 1'b0;
                        end
                    endcase
                end
            end
            alu32f_pkg::ST_ITER: begin
                n_cnt = r_cnt - CW'(1);
                if (r_func == alu32f_pkg::FN_MUL) begin
                    n_hi = au_sum[DW:1];
                    n_lo = {au_sum[0], r_lo[DW-1:1]};
                end else begin
                    n_hi = div_ge ? au_sum[DW-1:0] : {r_hi[DW-2:0], r_lo[DW-1]};
                    n_lo = {r_lo[DW-2:0], div_ge};
                end
            end
            alu32f_pkg::ST_FIX: begin
                n_res = au_sum[DW-1:0];
                if (r_func == alu32f_pkg::FN_MUL) begin
                    // The magnitude product must fit below 2^(DW-1), or equal
                    // it when the result is negative.
                    n_ovf = (r_hi != '0) ||
                            (r_lo[DW-1] && (!r_neg || (r_lo[DW-2:0] != '0)));
                end
            end
            alu32f_pkg::ST_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_res   = r_res;
                    n_m_ovf   = r_ovf;
                    n_m_dbz   = r_dbz;
                    if (r_wr) begin
                        n_last = r_res;
                    end
                end
            end
            default: begin
                n_m_valid = r_m_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= alu32f_pkg::ST_IDLE;
            r_m_valid <= 1'b0;
            r_last    <= '0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            r_last    <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_neg   <= n_neg;
        r_cnt   <= n_cnt;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_y     <= n_y;
        r_res   <= n_res;
        r_ovf   <= n_ovf;
        r_dbz   <= n_dbz;
        r_wr    <= n_wr;
        r_m_res <= n_m_res;
        r_m_ovf <= n_m_ovf;
        r_m_dbz <= n_m_dbz;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = {r_m_dbz, r_m_ovf};

    always_comb begin
        m_axis_tdata         = '0;
        m_axis_tdata[DW-1:0] = r_m_res;
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 32-bit integer ALU with overflow and
// divide-by-zero flags. Requests go in on the slave stream and results come
// back on the master stream. A scoreboard predicts each result, including
// the held last value, when a request is accepted and checks results in
// order. The stimulus opens with hand-picked corner cases and then runs
// random requests. Both sides stall in random bursts until the closing stretch.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW              = 32;
    localparam int FN_W            = alu32f_pkg::FUNC_W;
    localparam int S_TDATA_W       = ((2*DW+7)/8)*8;
    localparam int M_TDATA_W       = ((DW+7)/8)*8;
    localparam int RANDOM_REQUESTS = 1400;
    // Stall-free stretch at the close of the run, counted in requests.
    localparam int QUIET_TAIL      = 200;
    // Sized for the slowest legal request with the longest pause and result
    // stall, over about 1430 requests.
    localparam int CYCLE_LIMIT     = 500000;
    localparam int MAX_REPORTS     = 10;

    // Operation codes the block does not decode.
    localparam logic [FN_W-1:0] FN_UNUSED_LO = 4'd12;
    localparam logic [FN_W-1:0] FN_UNUSED_HI = 4'd15;

    localparam logic [DW-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [DW-1:0] MOST_POS = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] MINUS_ONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [DW-1:0] value;
        logic          overflow;
        logic          div_zero;
    } t_alu_outcome;

    // The scoreboard keeps its own copy of the held result. Each accepted
    // request is turned into one expected outcome at once. Results are then
    // matched in arrival order, since the block has only one request in flight.
    class t_alu_result_board;
        logic [DW-1:0] held_result;
        t_alu_outcome  expected_results[$];
        int            mismatches;

        function new();
            held_result = '0;
            mismatches  = 0;
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t mismatch: %s", $realtime, msg);
        endfunction

        function t_alu_outcome predict(logic [FN_W-1:0] fn, logic [DW-1:0] a,
                                       logic [DW-1:0] b);
            t_alu_outcome    outcome;
            logic            write;
            logic [DW-1:0]   mag_a;
            logic [DW-1:0]   mag_b;
            logic [DW-1:0]   part;
            logic [2*DW-1:0] product;

            outcome = '{value: held_result, overflow: 1'b0, div_zero: 1'b0};
            write   = 1'b1;
            mag_a   = a[DW-1] ? -a : a;
            mag_b   = b[DW-1] ? -b : b;
            case (fn)
                alu32f_pkg::FN_ADD: begin
                    outcome.value    = a + b;
                    outcome.overflow = (a[DW-1] == b[DW-1]) &&
                                       (outcome.value[DW-1] != a[DW-1]);
                end
                alu32f_pkg::FN_SUB: begin
                    outcome.value    = a - b;
                    outcome.overflow = (a[DW-1] != b[DW-1]) &&
                                       (outcome.value[DW-1] != a[DW-1]);
                end
                alu32f_pkg::FN_MUL: begin
                    // The exact signed product fits in twice the width. It
                    // overflows when the upper half is not a sign extension.
                    product = $signed({{DW{a[DW-1]}}, a}) * $signed({{DW{b[DW-1]}}, b});
                    outcome.value    = product[DW-1:0];
                    outcome.overflow = product != {{DW{product[DW-1]}}, product[DW-1:0]};
                end
                alu32f_pkg::FN_DIV, alu32f_pkg::FN_MOD: begin
                    if (b == '0) begin
                        // A zero divisor repeats the held value and keeps it.
                        outcome.div_zero = 1'b1;
                        write            = 1'b0;
                    end else if (fn == alu32f_pkg::FN_DIV) begin
                        // Quotients truncate towards zero. The most negative
                        // value divided by minus one wraps back to itself.
                        part          = mag_a / mag_b;
                        outcome.value = (a[DW-1] ^ b[DW-1]) ? -part : part;
                    end else begin
                        part          = mag_a % mag_b;
                        outcome.value = a[DW-1] ? -part : part;
                    end
                end
                alu32f_pkg::FN_AND: outcome.value = a & b;
                alu32f_pkg::FN_OR:  outcome.value = a | b;
                alu32f_pkg::FN_XOR: outcome.value = a ^ b;
                alu32f_pkg::FN_NOT: outcome.value = ~a;
                // Shift counts are unsigned, so a negative count is a huge one.
                alu32f_pkg::FN_SHL: outcome.value = (b >= DW) ? '0 : (a << b[4:0]);
                alu32f_pkg::FN_SHR: outcome.value = (b >= DW) ? '0 : (a >> b[4:0]);
                alu32f_pkg::FN_SHRA: begin
                    if (b >= DW)
                        outcome.value = {DW{a[DW-1]}};
                    else
                        outcome.value = $signed(a) >>> b[4:0];
                end
                default: write = 1'b0;
            endcase
            if (write)
                held_result = outcome.value;
            return outcome;
        endfunction

        function void note_request(logic [FN_W-1:0] fn, logic [DW-1:0] a,
                                   logic [DW-1:0] b);
            expected_results.push_back(predict(fn, a, b));
        endfunction

        function void check_result(logic [DW-1:0] value, logic [1:0] flags);
            t_alu_outcome want;

            if (expected_results.size() == 0) begin
                report($sformatf("result %h with no request waiting", value));
                return;
            end
            want = expected_results.pop_front();
            if (value !== want.value)
                report($sformatf("result expected %h actual %h", want.value, value));
            if (flags[0] !== want.overflow)
                report($sformatf("overflow expected %b actual %b", want.overflow, flags[0]));
            if (flags[1] !== want.div_zero)
                report($sformatf("divide_by_zero expected %b actual %b",
                                 want.div_zero, flags[1]));
        endfunction

        function void close_out();
            if (expected_results.size() != 0)
                report($sformatf("%0d results never arrived", expected_results.size()));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [FN_W-1:0]      s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]           m_axis_tuser;

    t_alu_result_board board = new();
    bit                quiet_tail    = 1'b0;
    int                calm_requests = 0;
    int                cycle_count   = 0;

    alu_32bit_with_flags #(
        .DATA_WIDTH (DW)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // operand_a, operand_b
        .s_axis_tuser  (s_axis_tuser),   // func
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // result
        .m_axis_tuser  (m_axis_tuser)    // overflow, divide_by_zero
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // The timeout guard. A hang anywhere ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Each result is sampled at the edge where it is taken. Values are read
    // before that edge's updates land, so no race arises with the block.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata[DW-1:0], m_axis_tuser);
    end

    // The result side mostly accepts, with stalls between ready stretches of
    // varied length. The closing stretch has no stalls.
    initial begin
        forever begin
            if (quiet_tail || $urandom_range(0, 2) != 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // This drives one request and returns at the edge that accepts it. The
    // request is noted there, so the held result follows the order of
    // acceptance. A pause may come first, except during calm stretches
    // and the closing stretch. Without a pause, valid stays high from the
    // previous request.
    task automatic send_request(logic [FN_W-1:0] fn, logic [DW-1:0] a,
                                logic [DW-1:0] b);
        if (calm_requests > 0) begin
            calm_requests--;
        end else if ($urandom_range(0, 29) == 0) begin
            calm_requests = $urandom_range(20, 60);
        end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= fn;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(fn, a, b);
    endtask

    // A random operand. Most are fully random words. The rest are extremes,
    // small signed values near zero, or random words cut to a shorter length.
    function automatic logic [DW-1:0] pick_operand();
        logic [DW-1:0] v;

        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = '0;
                    1:       v = 1;
                    2:       v = MINUS_ONE;
                    3:       v = MOST_NEG;
                    default: v = MOST_POS;
                endcase
            end
            1, 2: begin
                v = $urandom_range(0, 40);
                v = v - 20;
            end
            3:       v = $urandom >> $urandom_range(0, DW-1);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial begin
        logic [FN_W-1:0] fn;
        logic [DW-1:0]   a;
        logic [DW-1:0]   b;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= alu32f_pkg::FN_ADD;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A zero divisor straight after reset repeats the cleared value.
        send_request(alu32f_pkg::FN_DIV,  32'd5,     '0);
        // Overflow at both ends for add and subtract.
        send_request(alu32f_pkg::FN_ADD,  MOST_POS,  32'd1);
        send_request(alu32f_pkg::FN_ADD,  MOST_NEG,  MOST_NEG);
        send_request(alu32f_pkg::FN_ADD,  MINUS_ONE, 32'd1);
        send_request(alu32f_pkg::FN_SUB,  MOST_NEG,  32'd1);
        send_request(alu32f_pkg::FN_SUB,  MOST_POS,  MINUS_ONE);
        // Multiply: overflow of positive products and an exact fit at the most negative.
        send_request(alu32f_pkg::FN_MUL,  MOST_POS,  32'd2);
        send_request(alu32f_pkg::FN_MUL,  MOST_NEG,  MINUS_ONE);
        send_request(alu32f_pkg::FN_MUL,  32'h0001_0000, 32'h0001_0000);
        send_request(alu32f_pkg::FN_MUL,  32'hFFFF_0000, 32'h0000_8000);
        // Truncating divide and remainder with mixed signs.
        send_request(alu32f_pkg::FN_DIV,  32'd7,     32'hFFFF_FFFE);
        send_request(alu32f_pkg::FN_MOD,  32'hFFFF_FFF9, 32'd2);
        // A zero divisor must hold the previous value for both operations.
        send_request(alu32f_pkg::FN_DIV,  MOST_POS,  '0);
        send_request(alu32f_pkg::FN_MOD,  MOST_NEG,  '0);
        // The most negative value over minus one wraps, and its remainder is zero.
        send_request(alu32f_pkg::FN_DIV,  MOST_NEG,  MINUS_ONE);
        send_request(alu32f_pkg::FN_MOD,  MOST_NEG,  MINUS_ONE);
        send_request(alu32f_pkg::FN_AND,  32'hF0F0_A5A5, 32'hFF00_0FF0);
        send_request(alu32f_pkg::FN_OR,   32'hF0F0_A5A5, 32'h0F0F_0000);
        send_request(alu32f_pkg::FN_XOR,  MINUS_ONE, 32'h1234_5678);
        send_request(alu32f_pkg::FN_NOT,  32'h0F0F_0001, MINUS_ONE);
        // Shifts at the last in-range count, a full-width count and a negative count.
        send_request(alu32f_pkg::FN_SHL,  32'd3,     32'd31);
        send_request(alu32f_pkg::FN_SHL,  MINUS_ONE, 32'd32);
        send_request(alu32f_pkg::FN_SHR,  MOST_NEG,  32'd31);
        send_request(alu32f_pkg::FN_SHRA, MOST_NEG,  32'd40);
        send_request(alu32f_pkg::FN_SHRA, MOST_POS,  MINUS_ONE);
        // Unused codes repeat the held value with no flags set.
        send_request(FN_UNUSED_LO, 32'd1, 32'd1);
        send_request(FN_UNUSED_HI, '0,    '0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS - QUIET_TAIL)
                quiet_tail = 1'b1;
            if ($urandom_range(0, 19) == 0)
                fn = FN_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
            else
                fn = FN_W'($urandom_range(alu32f_pkg::FN_ADD, alu32f_pkg::FN_SHRA));
            a = pick_operand();
            b = pick_operand();
            // Shifts mostly get counts from zero to just past the width. Divides
            // get a zero divisor often enough to exercise the held value.
            if ((fn == alu32f_pkg::FN_SHL || fn == alu32f_pkg::FN_SHR ||
                 fn == alu32f_pkg::FN_SHRA) && $urandom_range(0, 3) != 0)
                b = $urandom_range(0, DW + 3);
            if ((fn == alu32f_pkg::FN_DIV || fn == alu32f_pkg::FN_MOD) &&
                $urandom_range(0, 7) == 0)
                b = '0;
            send_request(fn, a, b);
        end
        s_axis_tvalid <= 1'b0;

        while (board.expected_results.size() != 0)
            @(posedge i_clk);
        // Allow for any stray result after the last expected one.
        repeat (DW + 8) @(posedge i_clk);
        board.close_out();
        if (board.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== alu_32bit_with_flags.f =====
rtl/core/alu32f_pkg.sv
rtl/core/alu_32bit_with_flags.sv
dv/testbench.sv
